[hw/rtl/pcf_pkg.sv]
package pcf_pkg;

  localparam int MAX_ISLAND_SAMPLES = 4096;
  localparam int SAMPLE_BITS        = 14;
  localparam int PRE_START_SAMPLES  = 2;

  localparam int POS_BITS    = $clog2(MAX_ISLAND_SAMPLES);
  localparam int IDX_BITS    = 12;
  localparam int HEIGHT_BITS = SAMPLE_BITS + 2;
  localparam int PED_BITS    = 14;
  localparam int NOISE_BITS  = 14;
  localparam int TRIG_BITS   = 16;
  // wide enough for a height step and for the signed trigger level
  localparam int CMP_BITS    = (HEIGHT_BITS + 1 > TRIG_BITS + 1) ? HEIGHT_BITS + 1 : TRIG_BITS + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MODE_LEVEL        = 3'd0,
    CFG_POLARITY_NEGATIVE = 3'd1,
    CFG_PEDESTAL          = 3'd2,
    CFG_NOISE_LEVEL       = 3'd3,
    CFG_TRIGGER_LEVEL     = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic                        mode_level;
    logic                        polarity_negative;
    logic [PED_BITS-1:0]         pedestal;
    logic [NOISE_BITS-1:0]       noise_level;
    logic signed [TRIG_BITS-1:0] trigger_level;
  } cfg_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height;
    logic [POS_BITS-1:0]           pos;
    logic                          last;
  } item_t;

endpackage

[hw/rtl/pcf_front.sv]
module pcf_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcf_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                            last_of_island,
  input  pcf_pkg::cfg_t                   cfg,
  output logic                            q_valid,
  input  logic                            q_ready,
  output pcf_pkg::item_t                  q_item
);

  logic [pcf_pkg::POS_BITS-1:0] pos;
  logic [pcf_pkg::POS_BITS-1:0] pos_next;
  logic [pcf_pkg::SAMPLE_BITS-1:0] ped_s;
  logic signed [pcf_pkg::HEIGHT_BITS-1:0] s_ext;
  logic signed [pcf_pkg::HEIGHT_BITS-1:0] ped_ext;
  logic signed [pcf_pkg::HEIGHT_BITS-1:0] height;
  logic push;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign push     = in_valid && q_ready;

  // pedestal is taken to the sample width
  assign ped_s   = pcf_pkg::SAMPLE_BITS'(cfg.pedestal);
  assign s_ext   = signed'({2'b00, sample});
  assign ped_ext = signed'({2'b00, ped_s});
  assign height  = cfg.polarity_negative ? (ped_ext - s_ext) : (s_ext - ped_ext);

  always_comb begin
    if (last_of_island) begin
      pos_next = '0;
    end else if (32'(pos) == pcf_pkg::MAX_ISLAND_SAMPLES - 1) begin
      pos_next = '0;
    end else begin
      pos_next = pos + pcf_pkg::POS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      pos <= pos_next;
    end
  end

  always_comb begin
    q_item.height = height;
    q_item.pos    = pos;
    q_item.last   = last_of_island;
  end

endmodule

[hw/rtl/pcf_queue.sv]
module pcf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pcf_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pcf_pkg::item_t pop_item
);

  pcf_pkg::item_t entries [pcf_pkg::QUEUE_DEPTH];
  logic [pcf_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [pcf_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [pcf_pkg::QCNT_BITS-1:0] count;
  logic push;
  logic pop;

  assign push_ready = (32'(count) != pcf_pkg::QUEUE_DEPTH);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  function automatic logic [pcf_pkg::QPTR_BITS-1:0] ptr_inc(
    input logic [pcf_pkg::QPTR_BITS-1:0] p
  );
    if (32'(p) == pcf_pkg::QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + pcf_pkg::QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + pcf_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - pcf_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule

[hw/rtl/pcf_back.sv]
module pcf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  pcf_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  pcf_pkg::item_t               q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pcf_pkg::IDX_BITS-1:0] start_index,
  output logic [pcf_pkg::IDX_BITS-1:0] stop_index
);

  logic in_pulse;
  logic in_pulse_next;
  logic signed [pcf_pkg::HEIGHT_BITS-1:0] previous_height;
  logic [pcf_pkg::POS_BITS-1:0] pulse_start;
  logic [pcf_pkg::POS_BITS-1:0] pulse_start_next;
  logic [pcf_pkg::POS_BITS-1:0] baseline_position;
  logic [pcf_pkg::POS_BITS-1:0] baseline_position_next;
  logic baseline_seen;
  logic baseline_seen_next;

  logic pop;
  logic emit;
  logic pos_nz;
  logic evaluate;
  logic signed [pcf_pkg::CMP_BITS-1:0] h_c;
  logic signed [pcf_pkg::CMP_BITS-1:0] prev_c;
  logic signed [pcf_pkg::CMP_BITS-1:0] step;
  logic signed [pcf_pkg::CMP_BITS-1:0] trig_c;
  logic signed [pcf_pkg::CMP_BITS-1:0] noise_c;
  logic [pcf_pkg::POS_BITS-1:0] p_prev;
  logic [pcf_pkg::POS_BITS-1:0] rise_start;

  // output register frees up in the same cycle it is taken
  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  assign pos_nz   = (q_item.pos != '0);
  assign evaluate = cfg.mode_level || pos_nz;
  assign h_c      = pcf_pkg::CMP_BITS'(q_item.height);
  assign prev_c   = pcf_pkg::CMP_BITS'(previous_height);
  assign step     = h_c - prev_c;
  assign trig_c   = pcf_pkg::CMP_BITS'(cfg.trigger_level);
  assign noise_c  = signed'(pcf_pkg::CMP_BITS'(cfg.noise_level));

  // start sits a few samples before the previous one, clamped at zero
  assign p_prev     = q_item.pos - pcf_pkg::POS_BITS'(1);
  assign rise_start = (32'(p_prev) >= pcf_pkg::PRE_START_SAMPLES)
                    ? p_prev - pcf_pkg::POS_BITS'(pcf_pkg::PRE_START_SAMPLES) : '0;

  always_comb begin
    emit                   = 1'b0;
    in_pulse_next          = in_pulse;
    pulse_start_next       = pulse_start;
    baseline_position_next = baseline_position;
    baseline_seen_next     = baseline_seen;

    // trackback point includes the current sample
    if (pos_nz && (h_c[pcf_pkg::CMP_BITS-1] || (h_c == '0))) begin
      baseline_position_next = q_item.pos;
      baseline_seen_next     = 1'b1;
    end

    if (evaluate) begin
      if (in_pulse) begin
        if ((h_c < noise_c) || q_item.last) begin
          emit          = 1'b1;
          in_pulse_next = 1'b0;
        end
      end else if (!cfg.mode_level) begin
        if (step > trig_c) begin
          pulse_start_next = rise_start;
          in_pulse_next    = 1'b1;
        end
      end else begin
        if (h_c > trig_c) begin
          pulse_start_next = baseline_seen_next ? baseline_position_next : '0;
          in_pulse_next    = 1'b1;
        end
      end
    end

    // a pulse opened on the island's last sample is dropped
    if (q_item.last) begin
      in_pulse_next      = 1'b0;
      baseline_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_pulse          <= 1'b0;
      previous_height   <= '0;
      pulse_start       <= '0;
      baseline_position <= '0;
      baseline_seen     <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      out_valid <= (pop && emit) || (out_valid && !out_ready);
      if (pop) begin
        in_pulse          <= in_pulse_next;
        previous_height   <= q_item.height;
        pulse_start       <= pulse_start_next;
        baseline_position <= baseline_position_next;
        baseline_seen     <= baseline_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      start_index <= pcf_pkg::IDX_BITS'(pulse_start);
      stop_index  <= pcf_pkg::IDX_BITS'(q_item.pos);
    end
  end

endmodule

[hw/rtl/pulse_candidate_finder.sv]
// pulse candidate finder
// samples of one digitizer island come in on the in_valid/in_ready request
// channel, one per cycle while in_ready is high, with last_of_island set on
// the final sample. each closed pulse candidate leaves as one request on
// out_valid/out_ready carrying start_index and stop_index. the cfg channel
// writes mode, polarity, pedestal, noise and trigger levels by cfg_index;
// cfg_ready is always high and writes belong between islands while nothing
// is in flight. throughput: one sample per cycle while in_ready is high.
// the front computes the height and the sample index, a two-entry queue
// feeds the back, which tracks the pulse state and holds one result register.
// the front is combinational, so an accepted sample is written straight into
// the queue; the back pops it and registers the result in its output register.
// while the receiver stalls the result is held, the back stops, and the
// queue fills its two entries before in_ready drops.
// reset clears the configuration, the index counter and the pulse state,
// and empties the queue; the result fields are left as they are.
module pulse_candidate_finder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pcf_pkg::SAMPLE_BITS-1:0]     sample,
  input  logic                                last_of_island,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pcf_pkg::IDX_BITS-1:0]        start_index,
  output logic [pcf_pkg::IDX_BITS-1:0]        stop_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pcf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  pcf_pkg::cfg_t  cfg;
  pcf_pkg::item_t fq_item;
  pcf_pkg::item_t qb_item;
  logic fq_valid;
  logic fq_ready;
  logic qb_valid;
  logic qb_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcf_pkg::CFG_MODE_LEVEL:        cfg.mode_level        <= cfg_data[0];
        pcf_pkg::CFG_POLARITY_NEGATIVE: cfg.polarity_negative <= cfg_data[0];
        pcf_pkg::CFG_PEDESTAL:
          cfg.pedestal <= cfg_data[pcf_pkg::PED_BITS-1:0];
        pcf_pkg::CFG_NOISE_LEVEL:
          cfg.noise_level <= cfg_data[pcf_pkg::NOISE_BITS-1:0];
        pcf_pkg::CFG_TRIGGER_LEVEL:
          cfg.trigger_level <= signed'(cfg_data[pcf_pkg::TRIG_BITS-1:0]);
        default: ;
      endcase
    end
  end

  pcf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .last_of_island (last_of_island),
    .cfg            (cfg),
    .q_valid        (fq_valid),
    .q_ready        (fq_ready),
    .q_item         (fq_item)
  );

  pcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  pcf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (qb_valid),
    .q_ready     (qb_ready),
    .q_item      (qb_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .start_index (start_index),
    .stop_index  (stop_index)
  );

  // queue fills only when the back was held by a stalled result
  a_full_needs_stall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("queue filled while result register was free");

  // queue fills only through an accepted sample
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("queue filled without an accepted sample");

  // back never pops into a held result
  a_back_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !qb_ready)
    else $error("back took an item while result stalled");

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES   = 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_ROWS        = 36;

  typedef struct packed {
    logic [pcf_pkg::IDX_BITS-1:0] start_idx;
    logic [pcf_pkg::IDX_BITS-1:0] stop_idx;
  } pulse_span_t;

  typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;
  // how a sample row is checked: by the predictor, as no result, or as a typed span
  typedef enum {CHK_PREDICT, CHK_QUIET, CHK_SPAN} row_check_t;

  typedef struct {
    row_kind_t                         kind;
    pcf_pkg::cfg_index_t               reg_idx;
    logic [pcf_pkg::CFG_DATA_BITS-1:0] reg_data;
    logic [pcf_pkg::SAMPLE_BITS-1:0]   smp;
    logic                              last;
    row_check_t                        chk;
    logic [pcf_pkg::IDX_BITS-1:0]      exp_start;
    logic [pcf_pkg::IDX_BITS-1:0]      exp_stop;
  } stim_row_t;

  logic                               clk            = 1'b0;
  logic                               rst            = 1'b1;
  logic                               in_valid       = 1'b0;
  logic                               in_ready;
  logic [pcf_pkg::SAMPLE_BITS-1:0]    sample         = '0;
  logic                               last_of_island = 1'b0;
  logic                               out_valid;
  logic                               out_ready      = 1'b0;
  logic [pcf_pkg::IDX_BITS-1:0]       start_index;
  logic [pcf_pkg::IDX_BITS-1:0]       stop_index;
  logic                               cfg_valid      = 1'b0;
  logic                               cfg_ready;
  logic [pcf_pkg::CFG_INDEX_BITS-1:0] cfg_index      = '0;
  logic [pcf_pkg::CFG_DATA_BITS-1:0]  cfg_data       = '0;

  // configuration copy
  bit                                   lvl_mode  = 1'b0;
  bit                                   neg_pol   = 1'b0;
  logic [pcf_pkg::PED_BITS-1:0]         ped_cnt   = '0;
  logic [pcf_pkg::NOISE_BITS-1:0]       noise_cnt = '0;
  logic signed [pcf_pkg::TRIG_BITS-1:0] trig_cnt  = '0;

  // pulse tracking state
  bit                           pulse_open = 1'b0;
  int                           prev_h     = 0;
  logic [pcf_pkg::IDX_BITS-1:0] open_start = '0;
  logic [pcf_pkg::IDX_BITS-1:0] island_pos = '0;
  logic [pcf_pkg::IDX_BITS-1:0] quiet_pos  = '0;
  bit                           quiet_seen = 1'b0;

  pulse_span_t expected_spans[$];
  pulse_span_t want;
  int          fail_count    = 0;
  int          quiet_cycles  = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          jitter        = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // rise mode, all registers at reset
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd100, 1'b0, CHK_QUIET, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd100, 1'b0, CHK_QUIET, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd200, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd16383, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd0, 1'b1, CHK_SPAN, 12'd0, 12'd5},
    '{ROW_CFG, pcf_pkg::CFG_NOISE_LEVEL, 16'd50, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_TRIGGER_LEVEL, 16'd10, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    // rise with pre-start shift, then a pulse opening on the last sample
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd5, 1'b0, CHK_QUIET, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd5, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd5, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd5, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd100, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd20, 1'b0, CHK_SPAN, 12'd1, 12'd5},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd16383, 1'b1, CHK_QUIET, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_MODE_LEVEL, 16'd1, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_POLARITY_NEGATIVE, 16'd1, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_PEDESTAL, 16'd1000, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_NOISE_LEVEL, 16'd0, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_TRIGGER_LEVEL, 16'd100, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    // level mode, negative pulses, trackback to the last non-positive height
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd500, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd2000, 1'b0, CHK_SPAN, 12'd0, 12'd1},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd1000, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd800, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd900, 1'b1, CHK_SPAN, 12'd2, 12'd4},
    '{ROW_CFG, pcf_pkg::CFG_NOISE_LEVEL, 16'd16383, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_PEDESTAL, 16'd0, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_TRIGGER_LEVEL, 16'h8000, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    // most negative trigger: index 0 is no trackback point, the opener is one
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd16383, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd0, 1'b0, CHK_SPAN, 12'd0, 12'd1},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd7, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd3, 1'b1, CHK_SPAN, 12'd2, 12'd3},
    '{ROW_CFG, pcf_pkg::CFG_TRIGGER_LEVEL, 16'h7FFF, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_PEDESTAL, 16'd16383, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_CFG, pcf_pkg::CFG_POLARITY_NEGATIVE, 16'd0, 14'd0, 1'b0, CHK_PREDICT, 12'd0, 12'd0},
    '{ROW_SAMPLE, pcf_pkg::CFG_MODE_LEVEL, 16'd0, 14'd16383, 1'b1, CHK_QUIET, 12'd0, 12'd0}
  };

  pulse_candidate_finder u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .last_of_island (last_of_island),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .start_index    (start_index),
    .stop_index     (stop_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5ns clk = ~clk;

  // advances the pulse state by one sample, returns 1 when a candidate closes
  function automatic bit track_pulse(input logic [pcf_pkg::SAMPLE_BITS-1:0] s,
                                     input bit last, output pulse_span_t span);
    int h;
    bit fired;
    fired = 1'b0;
    span  = '0;
    h = neg_pol ? int'(ped_cnt) - int'(s) : int'(s) - int'(ped_cnt);
    if (island_pos != 0 && h <= 0) begin
      quiet_pos  = island_pos;
      quiet_seen = 1'b1;
    end
    // rise mode has no step on the first sample of an island
    if (lvl_mode || island_pos != 0) begin
      if (pulse_open) begin
        if (h < int'(noise_cnt) || last) begin
          span.start_idx = open_start;
          span.stop_idx  = island_pos;
          fired      = 1'b1;
          pulse_open = 1'b0;
        end
      end else if (!lvl_mode) begin
        if (h - prev_h > int'(trig_cnt)) begin
          open_start = (island_pos >= pcf_pkg::IDX_BITS'(pcf_pkg::PRE_START_SAMPLES + 1)) ?
                       island_pos - pcf_pkg::IDX_BITS'(pcf_pkg::PRE_START_SAMPLES + 1) : '0;
          pulse_open = 1'b1;
        end
      end else if (h > int'(trig_cnt)) begin
        open_start = quiet_seen ? quiet_pos : '0;
        pulse_open = 1'b1;
      end
    end
    prev_h     = h;
    island_pos = island_pos + 1'b1;
    if (last) begin
      island_pos = '0;
      quiet_seen = 1'b0;
      pulse_open = 1'b0;
    end
    return fired;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 200) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic write_reg(input pcf_pkg::cfg_index_t idx,
                           input logic [pcf_pkg::CFG_DATA_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pcf_pkg::CFG_MODE_LEVEL:        lvl_mode  = d[0];
      pcf_pkg::CFG_POLARITY_NEGATIVE: neg_pol   = d[0];
      pcf_pkg::CFG_PEDESTAL:          ped_cnt   = d[pcf_pkg::PED_BITS-1:0];
      pcf_pkg::CFG_NOISE_LEVEL:       noise_cnt = d[pcf_pkg::NOISE_BITS-1:0];
      pcf_pkg::CFG_TRIGGER_LEVEL:     trig_cnt  = d;
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [pcf_pkg::SAMPLE_BITS-1:0] s, input bit last,
                             input row_check_t chk, input pulse_span_t typed);
    pulse_span_t span;
    bit fired;
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    sample         <= s;
    last_of_island <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fired = track_pulse(s, last, span);
    case (chk)
      CHK_PREDICT: if (fired) expected_spans.insert(expected_spans.size(), span);
      CHK_SPAN:    expected_spans.insert(expected_spans.size(), typed);
      default: ;
    endcase
  endtask

  // stop sending and wait until every predicted span has come back
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic run_island(input int len);
    int i, v, amp, pulse_left, dir;
    pulse_left = 0;
    amp        = 0;
    dir        = neg_pol ? -1 : 1;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        v = $urandom_range(0, 16383);
      end else begin
        if (pulse_left == 0 && $urandom_range(0, 9) == 0) begin
          pulse_left = $urandom_range(1, 8);
          amp        = $urandom_range(0, 3000);
        end
        v = int'(ped_cnt) + int'($urandom_range(0, 2 * jitter)) - jitter;
        if (pulse_left > 0) begin
          v += dir * amp;
          amp = amp * 3 / 4;
          pulse_left--;
        end
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
      end
      send_sample(v[pcf_pkg::SAMPLE_BITS-1:0], i == len - 1, CHK_PREDICT, '0);
    end
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_spans.size() == 0) begin
        report_mismatch($sformatf("unexpected result start %0d stop %0d",
                                  start_index, stop_index));
      end else begin
        want = expected_spans.pop_front();
        if (start_index !== want.start_idx)
          report_mismatch($sformatf("start_index got %0d want %0d",
                                    start_index, want.start_idx));
        if (stop_index !== want.stop_idx)
          report_mismatch($sformatf("stop_index got %0d want %0d",
                                    stop_index, want.stop_idx));
      end
    end
  end

  // ends the run if no request moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int r, ph, sent, len;
    bit in_cfg, held;
    logic [pcf_pkg::CFG_DATA_BITS-1:0] ped_v, noise_v, trig_v;
    in_cfg    = 1'b0;
    held      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        if (!in_cfg) drain(SETTLE_CYCLES);
        in_cfg = 1'b1;
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
      end else begin
        in_cfg = 1'b0;
        send_sample(directed_rows[r].smp, directed_rows[r].last, directed_rows[r].chk,
                    {directed_rows[r].exp_start, directed_rows[r].exp_stop});
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain(SETTLE_CYCLES);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      case ($urandom_range(0, 5))
        0: ped_v = 16'd0;
        1: ped_v = 16'd16383;
        default: ped_v = 16'($urandom_range(0, 16383));
      endcase
      case ($urandom_range(0, 5))
        0: noise_v = 16'd0;
        1: noise_v = 16'd16383;
        default: noise_v = 16'($urandom_range(0, 300));
      endcase
      case ($urandom_range(0, 7))
        0: trig_v = 16'h8000;
        1: trig_v = 16'h7FFF;
        2: trig_v = 16'($urandom_range(0, 16'hFFFF));
        default: trig_v = 16'($urandom_range(0, 400));
      endcase
      jitter = $urandom_range(0, 20);
      write_reg(pcf_pkg::CFG_MODE_LEVEL, 16'($urandom_range(0, 1)));
      write_reg(pcf_pkg::CFG_POLARITY_NEGATIVE, 16'($urandom_range(0, 1)));
      write_reg(pcf_pkg::CFG_PEDESTAL, ped_v);
      write_reg(pcf_pkg::CFG_NOISE_LEVEL, noise_v);
      write_reg(pcf_pkg::CFG_TRIGGER_LEVEL, trig_v);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0: len = 1;
          1: len = 2;
          8, 9: len = $urandom_range(30, 120);
          default: len = $urandom_range(3, 30);
        endcase
        run_island(len);
        sent += len;
        if (ph == 1 && !held) begin
          drain(0);
          held = 1'b1;
        end
      end
    end

    drain(SETTLE_CYCLES);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
